// File: rtl/i2f_pkg.sv
`timescale 1ns / 1ps

package i2f_pkg;

	// Output format selected by the configuration register.
	typedef enum logic {
		FMT_SINGLE = 1'b0,
		FMT_DOUBLE = 1'b1
	} fmt_t;

	// Exponent biases of binary32 and binary64.
	localparam logic [7:0]  SP_BIAS = 8'd127;
	localparam logic [10:0] DP_BIAS = 11'd1023;

	// Fraction field widths.
	localparam int SP_FRAC_BITS = 23;
	localparam int DP_FRAC_BITS = 52;

	// Request after sign split: format, sign and magnitude.
	typedef struct packed {
		fmt_t        fmt;
		logic        sign;
		logic [63:0] mag;
	} mag_stage_t;

	// Request after leading-one detect.
	typedef struct packed {
		fmt_t        fmt;
		logic        sign;
		logic        zero;
		logic [5:0]  lead;
		logic [63:0] mag;
	} lead_stage_t;

endpackage

// File: rtl/i2f_lod.sv
`timescale 1ns / 1ps

module i2f_lod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s1,
	input  i2f_pkg::mag_stage_t      data_s1,
	output logic                     valid_s2,
	output i2f_pkg::lead_stage_t     data_s2
);
	import i2f_pkg::*;

	logic [5:0] lead;

	// Priority encoder: position of the highest set bit of the magnitude.
	always_comb begin
		lead = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (data_s1.mag[i]) begin
				lead = 6'(i);
			end
		end
	end

	// Valid bit of the second stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Payload of the second stage.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2.fmt  <= data_s1.fmt;
			data_s2.sign <= data_s1.sign;
			data_s2.zero <= (data_s1.mag == 64'd0);
			data_s2.lead <= lead;
			data_s2.mag  <= data_s1.mag;
		end
	end

endmodule

// File: rtl/i2f_norm.sv
`timescale 1ns / 1ps

module i2f_norm (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s2,
	input  i2f_pkg::lead_stage_t     data_s2,
	output logic                     valid_s3,
	output logic [63:0]              bits_s3
);
	import i2f_pkg::*;

	logic [63:0] norm;
	logic [63:0] packed_bits;

	// Shift the leading one up to bit 63; the fraction lies right below it.
	assign norm = data_s2.mag << (6'd63 - data_s2.lead);

	// Assemble sign, biased exponent and truncated fraction.
	always_comb begin
		if (data_s2.zero) begin
			packed_bits = 64'd0;
		end else if (data_s2.fmt == FMT_DOUBLE) begin
			packed_bits = {data_s2.sign, DP_BIAS + {5'd0, data_s2.lead},
				norm[62 -: DP_FRAC_BITS]};
		end else begin
			packed_bits = {32'd0, data_s2.sign, SP_BIAS + {2'd0, data_s2.lead},
				norm[62 -: SP_FRAC_BITS]};
		end
	end

	// Valid bit of the output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			bits_s3 <= packed_bits;
		end
	end

endmodule

// File: rtl/integer_to_ieee_float_bits_unit.sv
`timescale 1ns / 1ps

// Converts a signed 64-bit integer to its IEEE-754 bit pattern, binary32 in the
// low half (upper half zero) or binary64, as cfg_wdata last wrote through cfg_we.
// The fraction is truncated toward zero; zero gives +0.0. A request is taken on
// every cycle that start is high, since busy stays low: the three register stages
// (sign split, leading-one detect, normalize and pack) never stall. Each result
// appears on float_bits for one cycle with done high, in request order. The receiver
// cannot hold results off, so it must take each one in the cycle it is shown.
module integer_to_ieee_float_bits_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [63:0] int_value,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output logic               done,
	output logic [63:0]        float_bits
);
	import i2f_pkg::*;

	fmt_t        fmt_q;
	logic        valid_s1;
	mag_stage_t  data_s1;
	logic        valid_s2;
	lead_stage_t data_s2;

	// The pipeline never stalls.
	assign busy = 1'b0;

	// Format register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_SINGLE;
		end else if (cfg_we) begin
			fmt_q <= fmt_t'(cfg_wdata);
		end
	end

	// First stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// First stage: split sign and magnitude; the most negative value wraps to 2^63.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			data_s1.fmt  <= fmt_q;
			data_s1.sign <= int_value[63];
			data_s1.mag  <= int_value[63] ? (64'd0 - int_value) : int_value;
		end
	end

	i2f_lod u_lod (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	i2f_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (done),
		.bits_s3  (float_bits)
	);

	// A request produces exactly one result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##2 done)
		else $error("request did not produce a result after three cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ##2 !done)
		else $error("result without a request");

	// Zero converts to +0.0 in either format.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && int_value == 64'sd0) |=> ##2 (float_bits == 64'd0))
		else $error("zero did not convert to +0.0");

	// Single results leave the upper half clear.
	a_single_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && fmt_q == FMT_SINGLE) |=> ##2 (float_bits[63:32] == 32'd0))
		else $error("single result with upper bits set");

endmodule
